[src/euler_body_step_with_walls_assert.svh]
// Assertion macros for the Euler body step block
`ifndef EULER_BODY_STEP_WITH_WALLS_ASSERT_SVH
`define EULER_BODY_STEP_WITH_WALLS_ASSERT_SVH
`ifndef SYNTHESIS
`define EBS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define EBS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define EBS_ASSERT_IMPL(label, clk, rst, a, c)
`define EBS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[src/ebs_pkg.sv]
// Types and constants shared by the Euler body step block
`timescale 1ns / 1ps
`default_nettype none
package ebs_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd7;
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [16:0]        frame_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIV_X, ST_DIV_Y, ST_ACC, ST_TRIAL, ST_CHECK,
    ST_VEL, ST_POS, ST_COMMIT, ST_RESTART
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_y;
    logic acc;
    logic trial;
    logic check;
    logic vel;
    logic pos;
    logic commit;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

[src/euler_body_step_with_walls.sv]
// Top level of the Euler body step block with wall collisions
`timescale 1ns / 1ps
`default_nettype none
// One item per frame: an integrate item runs the bit-serial divider once for each
// force component, and a restart item skips it. A stalled output holds the
// sequencer in its last state. The next item is taken only once the previous
// result has moved into the output register.
`include "euler_body_step_with_walls_assert.svh"
module euler_body_step_with_walls #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ebs_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ebs_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [ebs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]         cfg_data
);
  logic [30:0] body_mass, body_size, area_width, area_height, floor_offset;
  logic signed [31:0] gravity_term, start_x, start_y;
  ebs_pkg::cmd_t cmd;
  ebs_pkg::stat_t stat;
  ebs_pkg::out_item_t result;
  logic busy, take, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mass <= 31'd65536; body_size <= 31'd65536; gravity_term <= '0;
      area_width <= 31'd52428800; area_height <= 31'd29491200; floor_offset <= '0;
      start_x <= '0; start_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ebs_pkg::REG_MASS: body_mass <= cfg_data[30:0];
        ebs_pkg::REG_SIZE: body_size <= cfg_data[30:0];
        ebs_pkg::REG_GRAV: gravity_term <= cfg_data;
        ebs_pkg::REG_WIDTH: area_width <= cfg_data[30:0];
        ebs_pkg::REG_HEIGHT: area_height <= cfg_data[30:0];
        ebs_pkg::REG_FLOOR: floor_offset <= cfg_data[30:0];
        ebs_pkg::REG_START_X: start_x <= cfg_data;
        ebs_pkg::REG_START_Y: start_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign take = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  ebs_ctrl u_ctrl (
    .clk, .rst, .start(take), .restart_cmd(in_data.command == ebs_pkg::CMD_RESTART),
    .out_free, .stat, .cmd, .busy
  );

  ebs_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .item(in_data), .item_take(take),
    .body_mass, .body_size, .gravity_term, .area_width, .area_height,
    .floor_offset, .start_x, .start_y, .stat, .result
  );

  logic emit, emit_d;
  assign emit = cmd.commit || cmd.restart;
  always_ff @(posedge clk) begin
    if (rst) emit_d <= 1'b0;
    else emit_d <= emit;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_d) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (emit_d) out_data <= result;
  end

  `EBS_ASSERT_IMPL(a_no_take_busy, clk, rst, busy, !take)
  `EBS_ASSERT_NEXT(a_emit_valid, clk, rst, emit_d, out_valid)
  `EBS_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.commit, cmd.restart, cmd.trial}))
endmodule
`default_nettype wire

[src/ebs_ctrl.sv]
// Sequencer for one body step item
`timescale 1ns / 1ps
`default_nettype none
module ebs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         restart_cmd,
  input  wire logic         out_free,
  input  wire ebs_pkg::stat_t stat,
  output ebs_pkg::cmd_t     cmd,
  output logic              busy
);
  ebs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ebs_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ebs_pkg::ST_IDLE: begin
        if (start) state_next = restart_cmd ? ebs_pkg::ST_RESTART : ebs_pkg::ST_LOAD;
      end
      ebs_pkg::ST_LOAD: state_next = ebs_pkg::ST_DIV_X;
      ebs_pkg::ST_DIV_X: if (stat.div_done) state_next = ebs_pkg::ST_DIV_Y;
      ebs_pkg::ST_DIV_Y: if (stat.div_done) state_next = ebs_pkg::ST_ACC;
      ebs_pkg::ST_ACC: state_next = ebs_pkg::ST_TRIAL;
      ebs_pkg::ST_TRIAL: state_next = ebs_pkg::ST_CHECK;
      ebs_pkg::ST_CHECK: state_next = ebs_pkg::ST_VEL;
      ebs_pkg::ST_VEL: state_next = ebs_pkg::ST_POS;
      ebs_pkg::ST_POS: state_next = ebs_pkg::ST_COMMIT;
      ebs_pkg::ST_COMMIT, ebs_pkg::ST_RESTART: begin
        if (out_free) state_next = ebs_pkg::ST_IDLE;
      end
      default: state_next = ebs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ebs_pkg::ST_IDLE);
    case (state)
      ebs_pkg::ST_LOAD: cmd.div_start = 1'b1;
      ebs_pkg::ST_DIV_X: begin
        cmd.div_sel_y = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.load = stat.div_done;
      end
      ebs_pkg::ST_ACC: cmd.acc = 1'b1;
      ebs_pkg::ST_TRIAL: cmd.trial = 1'b1;
      ebs_pkg::ST_CHECK: cmd.check = 1'b1;
      ebs_pkg::ST_VEL: cmd.vel = 1'b1;
      ebs_pkg::ST_POS: cmd.pos = 1'b1;
      ebs_pkg::ST_COMMIT: cmd.commit = out_free;
      ebs_pkg::ST_RESTART: cmd.restart = out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[src/ebs_datapath.sv]
// Datapath: radix-2 divider, dt multiplier, wall tests and body state
`timescale 1ns / 1ps
`default_nettype none
module ebs_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ebs_pkg::cmd_t     cmd,
  input  wire ebs_pkg::in_item_t item,
  input  wire logic              item_take,
  input  wire logic [30:0]       body_mass,
  input  wire logic [30:0]       body_size,
  input  wire logic signed [31:0] gravity_term,
  input  wire logic [30:0]       area_width,
  input  wire logic [30:0]       area_height,
  input  wire logic [30:0]       floor_offset,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  output ebs_pkg::stat_t         stat,
  output ebs_pkg::out_item_t     result
);
  localparam int unsigned NUM_W = 32 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic signed [31:0] fx, fy;
  logic [16:0] dt;
  logic signed [31:0] px, py, vx, vy;
  logic signed [31:0] ax, ay;
  logic signed [65:0] tx, ty;
  logic in_x, in_y, neg_x;

  // restoring divider on magnitudes
  logic [NUM_W-1:0] quo;
  logic [31:0] rem;
  logic [CNT_W-1:0] cnt;
  logic div_run, div_neg, div_zero;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  always_ff @(posedge clk) begin
    if (item_take) begin
      fx <= item.force_x;
      fy <= item.force_y;
      dt <= item.frame_time;
    end
  end

  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    rem_sub = rem_sh - {2'b0, body_mass};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else if (cmd.div_start) begin
      logic signed [31:0] f;
      logic [31:0] mag;
      f = cmd.div_sel_y ? fy : fx;
      mag = f[31] ? (~f + 32'd1) : f;
      quo <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      cnt <= CNT_W'(NUM_W);
      div_neg <= f[31];
      div_zero <= (f == 32'sd0);
      div_run <= 1'b1;
    end else if (div_run) begin
      if (cnt == '0) begin
        div_run <= 1'b0;
      end else begin
        if (!rem_sub[32]) begin
          rem <= rem_sub[31:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  logic signed [31:0] div_res;
  logic signed [NUM_W+1:0] qs;
  always_comb begin
    qs = div_neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    if (body_mass == 31'd0)
      div_res = div_zero ? 32'sd0 : (div_neg ? 32'sh80000000 : 32'sh7fffffff);
    else
      div_res = ebs_pkg::sat32(66'(qs));
  end
  assign stat.div_done = div_run && (cnt == '0);

  // load marks the end of the x division
  logic signed [31:0] ay_raw;
  always_ff @(posedge clk) begin
    if (stat.div_done && cmd.load) ax <= div_res;
    if (stat.div_done && !cmd.load) ay_raw <= div_res;
  end

  // dt product, floor shift
  function automatic logic signed [65:0] fsh(input logic signed [33:0] v,
                                             input logic [16:0] d);
    logic signed [51:0] p;
    p = v * $signed({1'b0, d});
    return 66'(p >>> FRAC_BITS);
  endfunction

  logic signed [31:0] xb, yb;
  always_comb begin
    xb = ebs_pkg::sat32(66'($signed({2'b0, area_width})) - 66'($signed({2'b0, body_size})));
    yb = ebs_pkg::sat32(66'($signed({2'b0, area_height})) - 66'($signed({2'b0, body_size}))
                        - 66'($signed({2'b0, floor_offset})));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; vx <= '0; vy <= '0;
    end else begin
      if (cmd.acc)
        ay <= ebs_pkg::sat32(-66'(ebs_pkg::sat32(66'(ay_raw) + 66'(gravity_term))));
      if (cmd.trial) begin
        tx <= 66'(px) + fsh(34'(vx) + 34'(ax), dt);
        ty <= 66'(py) + fsh(34'(vy) + 34'(ay), dt);
      end
      if (cmd.check) begin
        in_x <= (tx < 66'(xb)) && (tx > 66'sd0);
        neg_x <= tx < 66'sd0;
        in_y <= ty < 66'(yb);
      end
      if (cmd.vel) begin
        if (in_x) vx <= ebs_pkg::sat32(66'(vx) + 66'(ax));
        else begin
          vx <= '0;
          if (neg_x) px <= '0;
          else if (tx > 66'(xb)) px <= xb;
        end
        if (in_y) vy <= ebs_pkg::sat32(66'(vy) + 66'(ay));
        else begin
          vy <= '0;
          py <= yb;
        end
      end
      if (cmd.pos) begin
        if (in_x) px <= ebs_pkg::sat32(66'(px) + fsh(34'(vx), dt));
        if (in_y) py <= ebs_pkg::sat32(66'(py) + fsh(34'(vy), dt));
      end
      if (cmd.restart) begin
        px <= start_x; py <= start_y; vx <= '0; vy <= '0;
      end
    end
  end

  assign result = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy};
endmodule
`default_nettype wire

[tb/euler_body_step_with_walls_test.sv]
// Self-checking testbench for the Euler body step block with wall collisions
`timescale 1ns / 1ps
module euler_body_step_with_walls_test;
  localparam int FB = 16;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam longint LIMIT = 64'd3000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  ebs_pkg::in_item_t in_data;
  ebs_pkg::out_item_t out_data;
  logic cfg_we;
  logic [ebs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  euler_body_step_with_walls #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // body model state and registers
  longint m_mass, m_size, m_width, m_height, m_floor, m_grav, m_sx, m_sy;
  longint px, py, vx, vy;

  ebs_pkg::in_item_t pending[$];
  ebs_pkg::out_item_t expected_states[$];
  int errors;
  longint cycles;
  int send_gap, recv_gap;

  function automatic longint clip(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  // floor division by 2^FB
  function automatic longint fl_shift(longint p);
    return p >>> FB;
  endfunction

  function automatic longint accel(longint f);
    if (m_mass == 0) return f > 0 ? S_MAX : (f < 0 ? S_MIN : 0);
    return clip((f * (64'sd1 << FB)) / m_mass);
  endfunction

  task automatic model_write(input logic [ebs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
    case (idx)
      ebs_pkg::REG_MASS: m_mass = longint'(v[30:0]);
      ebs_pkg::REG_SIZE: m_size = longint'(v[30:0]);
      ebs_pkg::REG_GRAV: m_grav = longint'($signed(v));
      ebs_pkg::REG_WIDTH: m_width = longint'(v[30:0]);
      ebs_pkg::REG_HEIGHT: m_height = longint'(v[30:0]);
      ebs_pkg::REG_FLOOR: m_floor = longint'(v[30:0]);
      ebs_pkg::REG_START_X: m_sx = longint'($signed(v));
      ebs_pkg::REG_START_Y: m_sy = longint'($signed(v));
      default: ;
    endcase
  endtask

  function automatic ebs_pkg::out_item_t body_step(input ebs_pkg::in_item_t it);
    longint ax, ay, xb, yb, tx, ty, dt;
    ebs_pkg::out_item_t r;
    if (it.command == ebs_pkg::CMD_RESTART) begin
      px = m_sx; py = m_sy; vx = 0; vy = 0;
    end else begin
      dt = longint'(it.frame_time);
      ax = accel(longint'(it.force_x));
      ay = clip(-clip(accel(longint'(it.force_y)) + m_grav));
      xb = clip(m_width - m_size);
      yb = clip(m_height - m_size - m_floor);
      tx = px + fl_shift((vx + ax) * dt);
      ty = py + fl_shift((vy + ay) * dt);
      if (tx < xb && tx > 0) begin
        vx = clip(vx + ax);
        px = clip(px + fl_shift(vx * dt));
      end else begin
        vx = 0;
        if (tx < 0) px = 0;
        else if (tx > xb) px = xb;
      end
      if (ty < yb) begin
        vy = clip(vy + ay);
        py = clip(py + fl_shift(vy * dt));
      end else begin
        vy = 0;
        py = yb;
      end
    end
    r.pos_x = px[31:0]; r.pos_y = py[31:0]; r.vel_x = vx[31:0]; r.vel_y = vy[31:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      expected_states.push_back(body_step(in_data));
      void'(pending.pop_front());
      in_valid <= 0;
      send_gap <= $urandom_range(0, 15);
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending.size() > 0) begin
        in_data <= pending[0];
        in_valid <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_states.size() == 0) begin
          $error("unexpected result");
          errors = errors + 1;
        end else begin
          ebs_pkg::out_item_t e;
          e = expected_states.pop_front();
          if (e.pos_x !== out_data.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, out_data.pos_x);
            errors = errors + 1;
          end
          if (e.pos_y !== out_data.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, out_data.pos_y);
            errors = errors + 1;
          end
          if (e.vel_x !== out_data.vel_x) begin
            $error("vel_x expected %0d actual %0d", e.vel_x, out_data.vel_x);
            errors = errors + 1;
          end
          if (e.vel_y !== out_data.vel_y) begin
            $error("vel_y expected %0d actual %0d", e.vel_y, out_data.vel_y);
            errors = errors + 1;
          end
        end
        recv_gap <= $urandom_range(0, 15);
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (cycles > LIMIT) begin
        $display("euler_body_step_with_walls_test NOT OK");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending.size() > 0 || expected_states.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ebs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    model_write(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic ebs_pkg::in_item_t frame(input logic [31:0] fx, input logic [31:0] fy,
                                              input logic [16:0] dt);
    ebs_pkg::in_item_t it;
    it.command = ebs_pkg::CMD_STEP; it.force_x = fx; it.force_y = fy; it.frame_time = dt;
    return it;
  endfunction

  function automatic ebs_pkg::in_item_t restart_item();
    ebs_pkg::in_item_t it;
    it.command = ebs_pkg::CMD_RESTART; it.force_x = $urandom; it.force_y = $urandom;
    it.frame_time = 17'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h4000) - 32'h2000;
    endcase
  endfunction

  function automatic logic [16:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'h1ffff;
      3: return 17'($urandom);
      default: return 17'($urandom_range(0, 17'h10000));
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] v;
    v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0004_0000);
    if ($urandom_range(0, 15) == 0) v = 0;
    reg_write(ebs_pkg::REG_MASS, v);
    reg_write(ebs_pkg::REG_SIZE,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000a_0000));
    reg_write(ebs_pkg::REG_GRAV, $urandom_range(0, 3) == 0 ? $urandom
                                 : $urandom_range(0, 32'h0004_0000) - 32'h2_0000);
    reg_write(ebs_pkg::REG_WIDTH,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0400_0000));
    reg_write(ebs_pkg::REG_HEIGHT,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0400_0000));
    reg_write(ebs_pkg::REG_FLOOR,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000));
    reg_write(ebs_pkg::REG_START_X,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0200_0000));
    reg_write(ebs_pkg::REG_START_Y,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0200_0000));
  endtask

  initial begin
    errors = 0; cycles = 0;
    m_mass = 65536; m_size = 65536; m_grav = 0; m_width = 52428800; m_height = 29491200;
    m_floor = 0; m_sx = 0; m_sy = 0;
    px = 0; py = 0; vx = 0; vy = 0;
    rst = 1; in_valid = 0; in_data = '0; out_stall = 0;
    cfg_we = 0; cfg_index = ebs_pkg::REG_MASS; cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset config, walls, extremes, zero mass
    pending.push_back(frame(32'h0001_0000, 32'h0001_0000, 17'h10000));
    pending.push_back(frame(32'hffff_0000, 32'h0, 17'h8000));
    pending.push_back(frame(32'h7fff_ffff, 32'h7fff_ffff, 17'h1ffff));
    pending.push_back(frame(32'h8000_0000, 32'h8000_0000, 17'h10000));
    pending.push_back(frame(32'h0, 32'h0, 17'h0));
    pending.push_back(restart_item());
    pending.push_back(frame(32'h0, 32'hffff_0000, 17'h10000));
    drain();
    reg_write(ebs_pkg::REG_START_X, 32'h0010_0000);
    reg_write(ebs_pkg::REG_START_Y, 32'h0010_0000);
    reg_write(ebs_pkg::REG_GRAV, 32'hffff_8000);
    pending.push_back(restart_item());
    // x trial lands exactly on the left wall: 16 - 16 = 0
    pending.push_back(frame(32'hfff0_0000, 32'h0, 17'h10000));
    pending.push_back(restart_item());
    pending.push_back(frame(32'h0002_0000, 32'h0001_0000, 17'h4000));
    drain();
    reg_write(ebs_pkg::REG_MASS, 32'h0);
    pending.push_back(frame(32'h0000_0001, 32'hffff_ffff, 17'h1));
    pending.push_back(frame(32'h0, 32'h0, 17'h10000));
    pending.push_back(frame(32'hffff_ffff, 32'h1, 17'h10000));
    drain();
    reg_write(ebs_pkg::REG_MASS, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_SIZE, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_WIDTH, 32'h0);
    reg_write(ebs_pkg::REG_HEIGHT, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_FLOOR, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_GRAV, 32'h8000_0000);
    pending.push_back(frame(32'h7fff_ffff, 32'h8000_0000, 17'h10000));
    pending.push_back(restart_item());
    drain();
    reg_write(ebs_pkg::REG_GRAV, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_WIDTH, 32'h7fff_ffff);
    reg_write(ebs_pkg::REG_SIZE, 32'h0);
    reg_write(ebs_pkg::REG_FLOOR, 32'h0);
    reg_write(ebs_pkg::REG_MASS, 32'h1);
    reg_write(ebs_pkg::REG_START_X, 32'h8000_0000);
    reg_write(ebs_pkg::REG_START_Y, 32'h7fff_ffff);
    pending.push_back(restart_item());
    pending.push_back(frame(32'h7fff_ffff, 32'h8000_0000, 17'h1ffff));
    drain();

    // random phases; mostly frames of a body moving in a sane area
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 0) begin
        reg_write(ebs_pkg::REG_MASS, 32'h0001_0000);
        reg_write(ebs_pkg::REG_SIZE, 32'h0001_0000);
        reg_write(ebs_pkg::REG_GRAV, 32'hffff_0000);
        reg_write(ebs_pkg::REG_WIDTH, 32'h0320_0000);
        reg_write(ebs_pkg::REG_HEIGHT, 32'h01c2_0000);
        reg_write(ebs_pkg::REG_FLOOR, 32'h0);
        reg_write(ebs_pkg::REG_START_X, 32'h0190_0000);
        reg_write(ebs_pkg::REG_START_Y, 32'h0064_0000);
      end else random_config();
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(0, 19) == 0) pending.push_back(restart_item());
        else pending.push_back(frame(rand_force(), rand_force(), rand_dt()));
      end
      drain();
    end

    if (errors == 0 && expected_states.size() == 0) begin
      $display("euler_body_step_with_walls_test OK");
    end else begin
      $display("euler_body_step_with_walls_test NOT OK");
    end
    $finish;
  end
endmodule
